/* src/rrbs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrbs_pkg
// Shared types and codes of the round-robin backend selector.
// ----------------------------------------------------------------------------
package rrbs_pkg;

    localparam logic [2:0] CMD_ACCEPT    = 3'd0;
    localparam logic [2:0] CMD_FAILED    = 3'd1;
    localparam logic [2:0] CMD_CONNECTED = 3'd2;
    localparam logic [2:0] CMD_CLOSED    = 3'd3;
    localparam logic [2:0] CMD_ADD       = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // Operations the controller asks of the datapath.
    localparam logic [3:0] OP_IDLE      = 4'd0;
    localparam logic [3:0] OP_LOAD      = 4'd1;  // latch item
    localparam logic [3:0] OP_CLEAR     = 4'd2;  // clearing pass step
    localparam logic [3:0] OP_RD_GROUP  = 4'd3;  // read group size/next at scan group
    localparam logic [3:0] OP_RD_SLOT   = 4'd4;  // issue slot read at scan index
    localparam logic [3:0] OP_TEST      = 4'd5;  // evaluate slot data
    localparam logic [3:0] OP_STEP      = 4'd6;  // advance scan index
    localparam logic [3:0] OP_NEXT_GRP  = 4'd7;  // advance scan group
    localparam logic [3:0] OP_COUNT_UP  = 4'd8;
    localparam logic [3:0] OP_COUNT_DN  = 4'd9;
    localparam logic [3:0] OP_SET_NEXT  = 4'd10;
    localparam logic [3:0] OP_ADD       = 4'd11;
    localparam logic [3:0] OP_RD_ADDR   = 4'd12; // slot read at item address
    localparam logic [3:0] OP_FO_INIT   = 4'd13; // scan start setup (accept and failover)
    localparam logic [3:0] OP_RESULT    = 4'd14;
    localparam logic [3:0] OP_ADV_GRP   = 4'd15; // advance scan group, keep its pointer

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] status;    // for OP_RESULT
        logic       zero_out;  // result all zero except status
        logic       use_start; // new_start = item start_channel
        logic       ns_zero;   // new_start = 0
    } rrbs_cmd_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       addr_ok;
        logic       grp_ok;     // group < GROUPS
        logic       grp_empty;  // size of scan group is 0
        logic       grp_last;   // scan group is the last one
        logic       grp_full;   // item group holds CHANNELS
        logic       steps_done; // k reached size
        logic       usable;
        logic       hit_start;  // failover index equals start
        logic       clear_done;
    } rrbs_sts_t;

endpackage

/* src/rrbs_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrbs_datapath
// Channel and group stores, scan registers and the result register.
// ----------------------------------------------------------------------------
module rrbs_datapath #(
    parameter int GROUPS   = 32,
    parameter int CHANNELS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rrbs_pkg::rrbs_cmd_t ctl,
    output rrbs_pkg::rrbs_sts_t sts,
    input  logic [2:0]          in_cmd,
    input  logic [4:0]          in_group,
    input  logic [3:0]          in_channel,
    input  logic [3:0]          in_start,
    input  logic                in_enabled,
    input  logic [15:0]         in_limit,
    output logic [1:0]          res_status,
    output logic [4:0]          res_group,
    output logic [3:0]          res_channel,
    output logic [3:0]          res_start
);
    localparam int GW    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int CW    = $clog2(CHANNELS);
    localparam int SW    = $clog2(CHANNELS + 1);
    // Each group owns a power-of-two block of slots addressed as {group, channel}.
    localparam int SLOTS = GROUPS * (1 << CW);
    localparam int AW    = GW + CW;

    // Per-slot store: {enabled, limit, count}, cleared by a sweep after reset.
    logic [32:0]   slot_mem [SLOTS];
    logic [SW-1:0] size_mem [GROUPS];
    logic [CW-1:0] next_mem [GROUPS];

    logic [2:0]    cmd_reg;
    logic [4:0]    grp_in_reg;
    logic [3:0]    ch_in_reg, start_reg;
    logic          en_reg;
    logic [15:0]   lim_reg;
    logic [GW-1:0] sg_reg;   // scan group
    logic [CW-1:0] idx_reg;
    logic [SW-1:0] k_reg;
    logic [SW-1:0] size_reg;
    logic [CW-1:0] gnext_reg;
    logic [32:0]   rd_reg;
    logic [AW-1:0] clr_reg;
    logic          clr_done_reg;
    logic          hit_reg;

    logic [AW-1:0] slot_addr;
    logic [CW-1:0] idx_wrap;
    logic [CW:0]   idx_inc;
    logic          item_addr_ok;

    assign item_addr_ok = ({27'd0, grp_in_reg} < 32'(GROUPS))
                          && ({28'd0, ch_in_reg} < 32'(CHANNELS));
    assign idx_inc  = {1'b0, idx_reg} + 1'b1;
    assign idx_wrap = ({{(SW > CW + 1 ? SW - CW - 1 : 0){1'b0}}, idx_inc} >= size_reg)
                      ? '0 : idx_inc[CW-1:0];
    assign slot_addr = {sg_reg, idx_reg};

    always_comb
    begin
        sts.cmd        = cmd_reg;
        sts.addr_ok    = item_addr_ok;
        sts.grp_ok     = {27'd0, grp_in_reg} < 32'(GROUPS);
        sts.grp_empty  = (size_reg == '0);
        sts.grp_last   = ({{(32-GW){1'b0}}, sg_reg} == 32'(GROUPS - 1));
        sts.grp_full   = (size_reg >= SW'(CHANNELS));
        sts.steps_done = (k_reg >= size_reg);
        sts.usable     = rd_reg[32] && ((rd_reg[31:16] == 16'd0)
                         || (rd_reg[15:0] < rd_reg[31:16]));
        sts.hit_start  = hit_reg;
        sts.clear_done = clr_done_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= '0;
            clr_done_reg <= 1'b0;
        end
        else if (ctl.op == rrbs_pkg::OP_CLEAR)
        begin
            clr_reg <= clr_reg + 1'b1;
            if (clr_reg == AW'(SLOTS - 1))
                clr_done_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (ctl.op)
            rrbs_pkg::OP_LOAD:
            begin
                cmd_reg    <= in_cmd;
                grp_in_reg <= in_group;
                ch_in_reg  <= in_channel;
                start_reg  <= in_start;
                en_reg     <= in_enabled;
                lim_reg    <= in_limit;
                // An accept scan always starts at group 0.
                sg_reg     <= '0;
                if (in_cmd != rrbs_pkg::CMD_ACCEPT && {27'd0, in_group} < 32'(GROUPS))
                    sg_reg <= in_group[GW-1:0];
                if ({28'd0, in_channel} < 32'(CHANNELS))
                    idx_reg <= in_channel[CW-1:0];
                else
                    idx_reg <= '0;
            end
            rrbs_pkg::OP_CLEAR:
            begin
                slot_mem[clr_reg] <= 33'd0;
                if (clr_reg[CW-1:0] == '0)
                begin
                    size_mem[clr_reg[AW-1:CW]] <= '0;
                    next_mem[clr_reg[AW-1:CW]] <= '0;
                end
            end
            rrbs_pkg::OP_RD_GROUP:
            begin
                size_reg  <= size_mem[sg_reg];
                gnext_reg <= next_mem[sg_reg];
                k_reg     <= '0;
            end
            rrbs_pkg::OP_RD_SLOT, rrbs_pkg::OP_RD_ADDR:
            begin
                // Note whether the index read is where the failover scan began.
                rd_reg  <= slot_mem[slot_addr];
                hit_reg <= ({{(32-CW){1'b0}}, idx_reg} == {28'd0, start_reg});
            end
            rrbs_pkg::OP_TEST:
            begin
            end
            rrbs_pkg::OP_STEP:
            begin
                idx_reg <= idx_wrap;
                k_reg   <= k_reg + 1'b1;
            end
            rrbs_pkg::OP_NEXT_GRP:
            begin
                next_mem[sg_reg] <= '0;
                sg_reg <= sg_reg + 1'b1;
            end
            rrbs_pkg::OP_ADV_GRP:
                sg_reg <= sg_reg + 1'b1;
            rrbs_pkg::OP_FO_INIT:
            begin
                // Start at the pointer (accept: 0 if past the size) or the next group's pointer (failover).
                if (cmd_reg == rrbs_pkg::CMD_ACCEPT)
                    idx_reg <= ({{(SW-CW){1'b0}}, gnext_reg} >= size_reg) ? '0 : gnext_reg;
                else
                    idx_reg <= gnext_reg;
            end
            rrbs_pkg::OP_COUNT_UP:
            begin
                if (rd_reg[15:0] != rrbs_pkg::COUNT_MAX)
                    slot_mem[slot_addr] <= {rd_reg[32:16], rd_reg[15:0] + 16'd1};
                if (cmd_reg == rrbs_pkg::CMD_ACCEPT)
                    next_mem[sg_reg] <= idx_wrap;
            end
            rrbs_pkg::OP_COUNT_DN:
            begin
                if (rd_reg[15:0] != 16'd0)
                    slot_mem[slot_addr] <= {rd_reg[32:16], rd_reg[15:0] - 16'd1};
            end
            rrbs_pkg::OP_SET_NEXT:
                next_mem[sg_reg] <= idx_wrap;
            rrbs_pkg::OP_ADD:
            begin
                slot_mem[{sg_reg, size_reg[CW-1:0]}] <= {en_reg, lim_reg, 16'd0};
                size_mem[sg_reg] <= size_reg + 1'b1;
            end
            rrbs_pkg::OP_RESULT:
            begin
                res_status <= ctl.status;
                if (ctl.zero_out)
                begin
                    res_group   <= '0;
                    res_channel <= '0;
                    res_start   <= '0;
                end
                else
                begin
                    res_group <= 5'(sg_reg);
                    if (cmd_reg == rrbs_pkg::CMD_ADD)
                        res_channel <= (ctl.status == rrbs_pkg::ST_OK)
                                       ? 4'(size_reg) : 4'd0;
                    else if (cmd_reg == rrbs_pkg::CMD_CONNECTED
                             || cmd_reg == rrbs_pkg::CMD_CLOSED)
                        res_channel <= ch_in_reg;
                    else
                        res_channel <= 4'(idx_reg);
                    if (cmd_reg == rrbs_pkg::CMD_ADD)
                        res_group <= grp_in_reg;
                    if (ctl.ns_zero)
                        res_start <= '0;
                    else if (ctl.use_start)
                        res_start <= start_reg;
                    else
                        res_start <= 4'(idx_reg);
                end
            end
            default:
            begin
            end
        endcase
    end
endmodule

/* src/rrbs_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrbs_ctrl
// Sequencer for the clearing pass, the scans and the per-command updates.
// ----------------------------------------------------------------------------
module rrbs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  rrbs_pkg::rrbs_sts_t sts,
    output rrbs_pkg::rrbs_cmd_t ctl
);
    localparam logic [4:0] S_CLEAR   = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_DISP    = 5'd2;
    localparam logic [4:0] S_AGRP    = 5'd3;  // accept: read group
    localparam logic [4:0] S_AINIT   = 5'd4;
    localparam logic [4:0] S_ARD     = 5'd5;
    localparam logic [4:0] S_ATEST   = 5'd6;
    localparam logic [4:0] S_ANEXT   = 5'd7;
    localparam logic [4:0] S_UP      = 5'd8;
    localparam logic [4:0] S_OK      = 5'd9;
    localparam logic [4:0] S_NONE    = 5'd10;
    localparam logic [4:0] S_FRD     = 5'd11; // failover: read item slot
    localparam logic [4:0] S_FDN     = 5'd12;
    localparam logic [4:0] S_FGRP    = 5'd13;
    localparam logic [4:0] S_FSTEP   = 5'd14;
    localparam logic [4:0] S_FRDS    = 5'd15;
    localparam logic [4:0] S_FTEST   = 5'd16;
    localparam logic [4:0] S_FOGRP   = 5'd17; // failover: other groups
    localparam logic [4:0] S_FORD    = 5'd18;
    localparam logic [4:0] S_FOINIT  = 5'd19;
    localparam logic [4:0] S_FOUP    = 5'd20;
    localparam logic [4:0] S_CGRP    = 5'd21; // connected
    localparam logic [4:0] S_CSET    = 5'd22;
    localparam logic [4:0] S_XRD     = 5'd23; // closed
    localparam logic [4:0] S_XDN     = 5'd24;
    localparam logic [4:0] S_DGRP    = 5'd25; // add
    localparam logic [4:0] S_DDO     = 5'd26;
    localparam logic [4:0] S_ZERO    = 5'd27;
    localparam logic [4:0] S_FULL    = 5'd28;
    localparam logic [4:0] S_FOK     = 5'd29;
    localparam logic [4:0] S_OUT     = 5'd30;
    localparam logic [4:0] S_FONEXT  = 5'd31;

    logic [4:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        ctl          = '0;
        ctl.op       = rrbs_pkg::OP_IDLE;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.op = rrbs_pkg::OP_CLEAR;
                if (sts.clear_done)
                begin
                    ctl.op     = rrbs_pkg::OP_IDLE;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
                if (s_valid)
                begin
                    ctl.op     = rrbs_pkg::OP_LOAD;
                    state_next = S_DISP;
                end
            S_DISP:
                unique case (sts.cmd)
                    rrbs_pkg::CMD_ACCEPT:    state_next = S_AGRP;
                    rrbs_pkg::CMD_FAILED:    state_next = sts.addr_ok ? S_FRD : S_NONE;
                    rrbs_pkg::CMD_CONNECTED: state_next = sts.addr_ok ? S_CGRP : S_ZERO;
                    rrbs_pkg::CMD_CLOSED:    state_next = sts.addr_ok ? S_XRD : S_ZERO;
                    rrbs_pkg::CMD_ADD:       state_next = sts.grp_ok ? S_DGRP : S_FULL;
                    default:                 state_next = S_ZERO;
                endcase
            S_AGRP:
            begin
                ctl.op     = rrbs_pkg::OP_RD_GROUP;
                state_next = S_AINIT;
            end
            S_AINIT:
            begin
                ctl.op     = rrbs_pkg::OP_FO_INIT;
                state_next = S_ARD;
            end
            S_ARD:
                if (sts.steps_done)
                    state_next = S_ANEXT;
                else
                begin
                    ctl.op     = rrbs_pkg::OP_RD_SLOT;
                    state_next = S_ATEST;
                end
            S_ATEST:
                if (sts.usable)
                    state_next = S_UP;
                else
                begin
                    ctl.op     = rrbs_pkg::OP_STEP;
                    state_next = S_ARD;
                end
            S_ANEXT:
            begin
                // A group passed over gets its pointer cleared, the last one too.
                ctl.op = rrbs_pkg::OP_NEXT_GRP;
                if (sts.grp_last)
                    state_next = S_NONE;
                else
                    state_next = S_AGRP;
            end
            S_UP:
            begin
                ctl.op     = rrbs_pkg::OP_COUNT_UP;
                state_next = S_OK;
            end
            S_OK:
            begin
                ctl.op     = rrbs_pkg::OP_RESULT;
                ctl.status = rrbs_pkg::ST_OK;
                state_next = S_OUT;
            end
            S_NONE:
            begin
                ctl.op       = rrbs_pkg::OP_RESULT;
                ctl.status   = rrbs_pkg::ST_NONE;
                ctl.zero_out = 1'b1;
                state_next   = S_OUT;
            end
            S_FRD:
            begin
                ctl.op     = rrbs_pkg::OP_RD_ADDR;
                state_next = S_FDN;
            end
            S_FDN:
            begin
                ctl.op     = rrbs_pkg::OP_COUNT_DN;
                state_next = S_FGRP;
            end
            S_FGRP:
            begin
                ctl.op     = rrbs_pkg::OP_RD_GROUP;
                state_next = S_FSTEP;
            end
            S_FSTEP:
                if (sts.steps_done)
                    state_next = S_FONEXT;
                else
                begin
                    ctl.op     = rrbs_pkg::OP_STEP;
                    state_next = S_FRDS;
                end
            S_FRDS:
            begin
                ctl.op     = rrbs_pkg::OP_RD_SLOT;
                state_next = S_FTEST;
            end
            S_FTEST:
                if (sts.hit_start)
                    state_next = S_FONEXT;
                else if (sts.usable)
                begin
                    ctl.op     = rrbs_pkg::OP_COUNT_UP;
                    state_next = S_FOK;
                end
                else
                    state_next = S_FSTEP;
            S_FOK:
            begin
                ctl.op        = rrbs_pkg::OP_RESULT;
                ctl.status    = rrbs_pkg::ST_OK;
                ctl.use_start = 1'b1;
                state_next    = S_OUT;
            end
            S_FONEXT:
                if (sts.grp_last)
                    state_next = S_NONE;
                else
                begin
                    // The following groups keep their pointers during failover.
                    ctl.op     = rrbs_pkg::OP_ADV_GRP;
                    state_next = S_FOGRP;
                end
            S_FOGRP:
            begin
                ctl.op     = rrbs_pkg::OP_RD_GROUP;
                state_next = S_FORD;
            end
            S_FORD:
            begin
                state_next = sts.grp_empty ? S_FONEXT : S_FOINIT;
            end
            S_FOINIT:
            begin
                ctl.op     = rrbs_pkg::OP_FO_INIT;
                state_next = S_FOUP;
            end
            S_FOUP:
            begin
                ctl.op     = rrbs_pkg::OP_RD_SLOT;
                state_next = S_UP;
            end
            S_CGRP:
            begin
                ctl.op     = rrbs_pkg::OP_RD_GROUP;
                state_next = S_CSET;
            end
            S_CSET:
            begin
                ctl.op     = rrbs_pkg::OP_SET_NEXT;
                state_next = S_XDN;
            end
            S_XRD:
            begin
                ctl.op     = rrbs_pkg::OP_RD_ADDR;
                state_next = S_XDN;
            end
            S_XDN:
            begin
                ctl.op = (sts.cmd == rrbs_pkg::CMD_CLOSED)
                         ? rrbs_pkg::OP_COUNT_DN : rrbs_pkg::OP_IDLE;
                state_next = S_DDO;
            end
            S_DGRP:
            begin
                ctl.op     = rrbs_pkg::OP_RD_GROUP;
                state_next = S_DDO;
            end
            S_DDO:
            begin
                ctl.op      = rrbs_pkg::OP_RESULT;
                ctl.status  = (sts.cmd == rrbs_pkg::CMD_ADD && sts.grp_full)
                              ? rrbs_pkg::ST_FULL : rrbs_pkg::ST_OK;
                ctl.ns_zero = 1'b1;
                state_next  = (sts.cmd == rrbs_pkg::CMD_ADD && !sts.grp_full)
                              ? S_FULL : S_OUT;
            end
            S_FULL:
            begin
                if (sts.cmd == rrbs_pkg::CMD_ADD && sts.grp_ok)
                begin
                    ctl.op     = rrbs_pkg::OP_ADD;
                    state_next = S_OUT;
                end
                else
                begin
                    ctl.op      = rrbs_pkg::OP_RESULT;
                    ctl.status  = rrbs_pkg::ST_FULL;
                    ctl.ns_zero = 1'b1;
                    state_next  = S_OUT;
                end
            end
            S_ZERO:
            begin
                ctl.op       = rrbs_pkg::OP_RESULT;
                ctl.status   = rrbs_pkg::ST_OK;
                ctl.zero_out = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (!m_valid_reg || m_ready)
                begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // A new result is written only once the previous one has left.
        if (ctl.op == rrbs_pkg::OP_RESULT && m_valid_reg && !m_ready)
        begin
            ctl        = '0;
            ctl.op     = rrbs_pkg::OP_IDLE;
            state_next = state_reg;
        end
    end
endmodule

/* src/round_robin_backend_selector.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_backend_selector
// Picks a backend channel per connection event over prioritized groups.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake          Payload
// s_axis    in   tvalid/tready      cmd, group, channel, start_channel, ...
// m_axis    out  tvalid/tready      status, chosen_group, chosen_channel, ...
//
// An accept scan steps through the groups passed over and the channels
// examined, bounded by the single-port slot store read in each step.
// After reset a clearing pass over all GROUPS*CHANNELS slots (CHANNELS rounded up
// to a power of two) runs before items.
// One item is worked at a time; the result sits in a register while the
// next item is taken, and the next result waits until that register is free.
// ----------------------------------------------------------------------------
module round_robin_backend_selector #(
    parameter int GROUPS   = 32,
    parameter int CHANNELS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd[2:0], group[7:3], channel[11:8], start_channel[15:12],
    // enabled[16], max_connections[32:17], zero fill to 40 bits
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], chosen_group[6:2], chosen_channel[10:7],
    // new_start_channel[14:11], zero fill to 16 bits
    output logic [15:0] m_axis_tdata
);
    rrbs_pkg::rrbs_cmd_t ctl;
    rrbs_pkg::rrbs_sts_t sts;
    logic [1:0] res_status;
    logic [4:0] res_group;
    logic [3:0] res_channel, res_start;

    rrbs_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .sts     (sts),
        .ctl     (ctl)
    );

    rrbs_datapath #(
        .GROUPS   (GROUPS),
        .CHANNELS (CHANNELS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .sts         (sts),
        .in_cmd      (s_axis_tdata[2:0]),
        .in_group    (s_axis_tdata[7:3]),
        .in_channel  (s_axis_tdata[11:8]),
        .in_start    (s_axis_tdata[15:12]),
        .in_enabled  (s_axis_tdata[16]),
        .in_limit    (s_axis_tdata[32:17]),
        .res_status  (res_status),
        .res_group   (res_group),
        .res_channel (res_channel),
        .res_start   (res_start)
    );

    assign m_axis_tdata = {1'b0, res_start, res_channel, res_group, res_status};
endmodule

/* tb/round_robin_backend_selector_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_backend_selector_tb
// Drives connection events into the selector and checks every result against the
// row's typed result or a behavioral predictor of the group and channel store kept in the bench.
// ----------------------------------------------------------------------------
module round_robin_backend_selector_tb;

    localparam int GROUPS     = 32;
    localparam int CHANNELS   = 16;
    localparam int RAND_ITEMS = 850;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [15:0] max_connections;
        logic        enabled;
        logic [3:0]  start_channel;
        logic [3:0]  channel;
        logic [4:0]  group;
        logic [2:0]  cmd;
    } event_t;

    typedef struct packed {
        logic [3:0] new_start_channel;
        logic [3:0] chosen_channel;
        logic [4:0] chosen_group;
        logic [1:0] status;
    } pick_t;

    typedef struct {
        event_t ev;
        logic   fixed;   // expected result typed in the row
        pick_t  res;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    round_robin_backend_selector #(.GROUPS(GROUPS), .CHANNELS(CHANNELS)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // Predictor copy of the backend store.
    logic        mdl_en    [GROUPS*CHANNELS];
    logic [15:0] mdl_limit [GROUPS*CHANNELS];
    logic [15:0] mdl_count [GROUPS*CHANNELS];
    logic [4:0]  mdl_size  [GROUPS];
    logic [3:0]  mdl_next  [GROUPS];

    pick_t  pending_picks[$];
    int     errors;
    int     sent;
    int     received;
    int     idle_cycles;
    int     row_idx;
    logic   hold_off;
    logic   no_idle;
    logic   done;
    row_t   rows[$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic can_take(int g, int c);
        int s;
        s = g * CHANNELS + c;
        return mdl_en[s] && (mdl_limit[s] == 0 || mdl_count[s] < mdl_limit[s]);
    endfunction

    function automatic int wrap_after(int g, int c);
        return (c + 1 >= mdl_size[g]) ? 0 : c + 1;
    endfunction

    function automatic pick_t mk(logic [1:0] st, int g, int c, int ns);
        pick_t p;
        p.status = st;
        p.chosen_group = g[4:0];
        p.chosen_channel = c[3:0];
        p.new_start_channel = ns[3:0];
        return p;
    endfunction

    function automatic void bump(int s);
        if (mdl_count[s] != rrbs_pkg::COUNT_MAX)
            mdl_count[s] = mdl_count[s] + 16'd1;
    endfunction

    function automatic void drop(int s);
        if (mdl_count[s] != 0)
            mdl_count[s] = mdl_count[s] - 16'd1;
    endfunction

    function automatic pick_t predict_pick(event_t ev);
        int g;
        int c;
        int idx;
        int s;
        g = ev.group;
        c = ev.channel;
        case (ev.cmd)
            rrbs_pkg::CMD_ACCEPT:
            begin
                for (int gi = 0; gi < GROUPS; gi++)
                begin
                    idx = mdl_next[gi];
                    if (idx >= mdl_size[gi])
                        idx = 0;
                    for (int k = 0; k < mdl_size[gi]; k++)
                    begin
                        if (can_take(gi, idx))
                        begin
                            mdl_next[gi] = 4'(wrap_after(gi, idx));
                            bump(gi * CHANNELS + idx);
                            return mk(rrbs_pkg::ST_OK, gi, idx, idx);
                        end
                        idx = wrap_after(gi, idx);
                    end
                    mdl_next[gi] = '0;
                end
                return mk(rrbs_pkg::ST_NONE, 0, 0, 0);
            end
            rrbs_pkg::CMD_FAILED:
            begin
                drop(g * CHANNELS + c);
                idx = c;
                for (int k = 0; k < mdl_size[g]; k++)
                begin
                    idx = wrap_after(g, idx);
                    if (idx == ev.start_channel)
                        break;
                    if (can_take(g, idx))
                    begin
                        bump(g * CHANNELS + idx);
                        return mk(rrbs_pkg::ST_OK, g, idx, ev.start_channel);
                    end
                end
                for (int k = g + 1; k < GROUPS; k++)
                begin
                    if (mdl_size[k] != 0)
                    begin
                        bump(k * CHANNELS + mdl_next[k]);
                        return mk(rrbs_pkg::ST_OK, k, mdl_next[k], mdl_next[k]);
                    end
                end
                return mk(rrbs_pkg::ST_NONE, 0, 0, 0);
            end
            rrbs_pkg::CMD_CONNECTED:
            begin
                mdl_next[g] = 4'(wrap_after(g, c));
                return mk(rrbs_pkg::ST_OK, g, c, 0);
            end
            rrbs_pkg::CMD_CLOSED:
            begin
                drop(g * CHANNELS + c);
                return mk(rrbs_pkg::ST_OK, g, c, 0);
            end
            rrbs_pkg::CMD_ADD:
            begin
                if (mdl_size[g] >= CHANNELS)
                    return mk(rrbs_pkg::ST_FULL, g, 0, 0);
                idx = mdl_size[g];
                s = g * CHANNELS + idx;
                mdl_en[s] = ev.enabled;
                mdl_limit[s] = ev.max_connections;
                mdl_count[s] = 0;
                mdl_size[g] = 5'(idx + 1);
                return mk(rrbs_pkg::ST_OK, g, idx, 0);
            end
            default:
                return mk(rrbs_pkg::ST_OK, 0, 0, 0);
        endcase
    endfunction

    function automatic event_t mk_ev(logic [2:0] cmd, int g, int c, int st, logic en,
                                     int lim);
        event_t e;
        e.cmd = cmd;
        e.group = g[4:0];
        e.channel = c[3:0];
        e.start_channel = st[3:0];
        e.enabled = en;
        e.max_connections = lim[15:0];
        return e;
    endfunction

    function automatic void add_row(event_t e, logic fixed, pick_t r);
        row_t rw;
        rw.ev = e;
        rw.fixed = fixed;
        rw.res = r;
        rows.push_back(rw);
    endfunction

    // Channels within existing groups are addressed most of the time so the
    // failover and close paths act on live entries.
    function automatic event_t random_event();
        int     sel;
        int     g;
        int     c;
        event_t e;
        sel = $urandom_range(0, 99);
        g = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 5);
        c = (mdl_size[g] != 0 && $urandom_range(0, 3) != 0) ?
            $urandom_range(0, mdl_size[g] - 1) : $urandom_range(0, 15);
        e = mk_ev(rrbs_pkg::CMD_ACCEPT, g, c, $urandom_range(0, 15),
                  ($urandom_range(0, 3) != 0),
                  ($urandom_range(0, 2) == 0) ? 0 :
                  (($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(1, 4)));
        if (sel < 35)
            e.cmd = rrbs_pkg::CMD_ACCEPT;
        else if (sel < 50)
            e.cmd = rrbs_pkg::CMD_FAILED;
        else if (sel < 60)
            e.cmd = rrbs_pkg::CMD_CONNECTED;
        else if (sel < 80)
            e.cmd = rrbs_pkg::CMD_CLOSED;
        else if (sel < 97)
            e.cmd = rrbs_pkg::CMD_ADD;
        else
            e.cmd = 3'($urandom_range(5, 7));
        return e;
    endfunction

    // Returns at the accepting edge with tvalid still high; an idle gap, if
    // any, drops tvalid at the start of the next call.
    task automatic send_event(event_t e);
        if (!no_idle && $urandom_range(0, 99) < 20)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while (!no_idle && $urandom_range(0, 99) < 20)
                @(posedge clk);
        end
        s_axis_tdata <= {7'd0, e};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Expectations are queued on the accepting edge, before any result of
    // that item can be seen by the monitor.
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            pick_t p;
            p = predict_pick(event_t'(s_axis_tdata[32:0]));
            if (row_idx < rows.size() && rows[row_idx].fixed)
                pending_picks.push_back(rows[row_idx].res);
            else
                pending_picks.push_back(p);
            sent++;
            row_idx++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            pick_t got;
            pick_t exp_p;
            got = m_axis_tdata[14:0];
            received++;
            if (pending_picks.size() == 0)
            begin
                $error("unexpected result %h", got);
                errors++;
            end
            else
            begin
                exp_p = pending_picks.pop_front();
                if (got.status !== exp_p.status)
                begin
                    $error("status: expected %0d actual %0d", exp_p.status, got.status);
                    errors++;
                end
                if (got.chosen_group !== exp_p.chosen_group)
                begin
                    $error("chosen_group: expected %0d actual %0d",
                           exp_p.chosen_group, got.chosen_group);
                    errors++;
                end
                if (got.chosen_channel !== exp_p.chosen_channel)
                begin
                    $error("chosen_channel: expected %0d actual %0d",
                           exp_p.chosen_channel, got.chosen_channel);
                    errors++;
                end
                if (got.new_start_channel !== exp_p.new_start_channel)
                begin
                    $error("new_start_channel: expected %0d actual %0d",
                           exp_p.new_start_channel, got.new_start_channel);
                    errors++;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off while items keep coming.
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
                m_axis_tready <= 1'b0;
            else
                m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 20);
        end
    end

    initial
    begin
        hold_off = 1'b0;
        wait (sent == 40);
        hold_off = 1'b1;
        repeat (2000) @(posedge clk);
        hold_off = 1'b0;
    end

    // Watchdog: cycles with no handshake on either side.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT && !done)
        begin
            $display("round_robin_backend_selector_tb: errors");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        errors = 0;
        sent = 0;
        received = 0;
        idle_cycles = 0;
        row_idx = 0;
        no_idle = 1'b0;
        done = 1'b0;
        for (int i = 0; i < GROUPS * CHANNELS; i++)
        begin
            mdl_en[i] = 1'b0;
            mdl_limit[i] = '0;
            mdl_count[i] = '0;
        end
        for (int i = 0; i < GROUPS; i++)
        begin
            mdl_size[i] = '0;
            mdl_next[i] = '0;
        end

        // Directed rows: empty store, extremes, every command, open cases.
        add_row(mk_ev(rrbs_pkg::CMD_ACCEPT, 0, 0, 0, 0, 0), 1,
                mk(rrbs_pkg::ST_NONE, 0, 0, 0));
        add_row(mk_ev(rrbs_pkg::CMD_FAILED, 31, 15, 15, 1, 65535), 1,
                mk(rrbs_pkg::ST_NONE, 0, 0, 0));
        add_row(mk_ev(rrbs_pkg::CMD_CONNECTED, 31, 15, 0, 0, 0), 1,
                mk(rrbs_pkg::ST_OK, 31, 15, 0));
        add_row(mk_ev(rrbs_pkg::CMD_CLOSED, 0, 0, 0, 0, 0), 1,
                mk(rrbs_pkg::ST_OK, 0, 0, 0));
        add_row(mk_ev(3'd5, 0, 0, 0, 0, 0), 1, mk(rrbs_pkg::ST_OK, 0, 0, 0));
        add_row(mk_ev(3'd7, 31, 15, 15, 1, 65535), 1, mk(rrbs_pkg::ST_OK, 0, 0, 0));
        add_row(mk_ev(rrbs_pkg::CMD_ADD, 31, 15, 15, 1, 65535), 1,
                mk(rrbs_pkg::ST_OK, 31, 0, 0));
        add_row(mk_ev(rrbs_pkg::CMD_ADD, 2, 0, 0, 1, 1), 1, mk(rrbs_pkg::ST_OK, 2, 0, 0));
        add_row(mk_ev(rrbs_pkg::CMD_ADD, 2, 0, 0, 0, 0), 1, mk(rrbs_pkg::ST_OK, 2, 1, 0));
        add_row(mk_ev(rrbs_pkg::CMD_ADD, 2, 0, 0, 1, 0), 1, mk(rrbs_pkg::ST_OK, 2, 2, 0));
        add_row(mk_ev(rrbs_pkg::CMD_ACCEPT, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk_ev(rrbs_pkg::CMD_ACCEPT, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk_ev(rrbs_pkg::CMD_ACCEPT, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk_ev(rrbs_pkg::CMD_FAILED, 2, 2, 2, 0, 0), 0, '0);
        add_row(mk_ev(rrbs_pkg::CMD_FAILED, 2, 0, 15, 0, 0), 0, '0);
        add_row(mk_ev(rrbs_pkg::CMD_CONNECTED, 2, 2, 0, 0, 0), 0, '0);
        add_row(mk_ev(rrbs_pkg::CMD_CLOSED, 2, 9, 0, 0, 0), 0, '0);
        add_row(mk_ev(rrbs_pkg::CMD_FAILED, 2, 12, 3, 0, 0), 0, '0);
        for (int i = 0; i < 7; i++)
            add_row(mk_ev(rrbs_pkg::CMD_ADD, 5, 0, 0, 1, 0), 0, '0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < rows.size(); i++)
            send_event(rows[i].ev);

        // Fill a group to its limit once so the full case is reached.
        for (int i = 0; i < CHANNELS + 1; i++)
            send_event(mk_ev(rrbs_pkg::CMD_ADD, 7, 0, 0, 1, 2));

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            no_idle = (i >= 300 && i < 400);
            send_event(random_event());
        end
        s_axis_tvalid <= 1'b0;
        no_idle = 1'b0;

        while (pending_picks.size() != 0 || hold_off)
            @(posedge clk);
        repeat (2000) @(posedge clk);
        done = 1'b1;

        $display("Sent %0d items and checked %0d results over accept, failover,", sent,
                 received);
        $display("connect, close, add, full-group and unknown-command cases.");
        if (errors == 0)
            $display("round_robin_backend_selector_tb: clean");
        else
            $display("round_robin_backend_selector_tb: errors");
        $finish;
    end

endmodule

/* filelist.f */
src/rrbs_pkg.sv
src/rrbs_datapath.sv
src/rrbs_ctrl.sv
src/round_robin_backend_selector.sv
tb/round_robin_backend_selector_tb.sv
